/* rtl/hkle_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and keyword tables for the HTTP keyword line extractor.
package hkle_pkg;

    localparam int CHUNK_BYTES = 1500;
    localparam int FIELD_MAX   = 1000;
    localparam int NKEY        = 3;

    localparam int POS_W   = $clog2(CHUNK_BYTES + 1);
    localparam int LEN_W   = $clog2(FIELD_MAX);
    localparam int START_W = 11;
    localparam int WIN_W   = 56;
    localparam int HIST_W  = 48;

    localparam logic [7:0] NEWLINE = 8'h0A;
    localparam logic [7:0] NUL     = 8'h00;

    typedef enum logic [1:0] {
        KIND_GET     = 2'd0,
        KIND_HOST    = 2'd1,
        KIND_REFERER = 2'd2
    } field_kind_t;

    localparam logic [WIN_W-1:0] KEY_PATTERN [NKEY] = '{
        56'h00000000474554, 56'h000000486F7374, 56'h52656665726572
    };
    localparam logic [WIN_W-1:0] KEY_MASK [NKEY] = '{
        56'h00000000FFFFFF, 56'h000000FFFFFFFF, 56'hFFFFFFFFFFFFFF
    };
    localparam logic [POS_W-1:0] KEY_LEN [NKEY] = '{
        POS_W'(3), POS_W'(4), POS_W'(7)
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  field_kind;
        logic [10:0] field_start;
        logic [9:0]  field_length;
        logic        field_truncated;
        logic        last_field;
    } field_item_t;

    // one keyword's line as reported at chunk end
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               truncated;
    } field_rec_t;

    typedef field_rec_t [NKEY-1:0] summary_t;

endpackage

/* rtl/hkle_front.sv */
`timescale 1ns / 1ps
// Byte tracker: window match, per-keyword span measurement, chunk summary at chunk end.
module hkle_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  hkle_pkg::byte_item_t byte_item,
    input  logic                q_full,
    output logic                q_push,
    output hkle_pkg::summary_t  q_data
);
    import hkle_pkg::*;

    logic [HIST_W-1:0]  recent_reg, recent_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               ended_reg, ended_next;
    logic [NKEY-1:0]    seen_reg, seen_next;
    logic [POS_W-1:0]   start_reg [NKEY];
    logic [POS_W-1:0]   start_next [NKEY];
    logic [NKEY-1:0]    open_reg, open_next;
    logic [LEN_W-1:0]   len_reg [NKEY];
    logic [LEN_W-1:0]   len_next [NKEY];
    logic [NKEY-1:0]    trunc_reg, trunc_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_nl_reg, pend_nl_next;
    logic [NKEY-1:0]    pend_match_reg, pend_match_next;

    logic accept;

    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;
    assign q_push     = accept && byte_item.chunk_end && (&seen_reg);

    always_comb
    begin
        for (int k = 0; k < NKEY; k++)
        begin
            q_data[k].start     = open_reg[k] ? '0 : START_W'(start_reg[k]);
            q_data[k].length    = open_reg[k] ? '0 : len_reg[k];
            q_data[k].truncated = !open_reg[k] && trunc_reg[k];
        end
    end

    always_comb
    begin
        logic [WIN_W-1:0] win;
        logic [POS_W-1:0] span;
        recent_next     = recent_reg;
        pos_next        = pos_reg;
        ended_next      = ended_reg;
        seen_next       = seen_reg;
        start_next      = start_reg;
        open_next       = open_reg;
        len_next        = len_reg;
        trunc_next      = trunc_reg;
        pend_valid_next = pend_valid_reg;
        pend_nl_next    = pend_nl_reg;
        pend_match_next = pend_match_reg;
        win             = {recent_reg, byte_item.data_byte};
        span            = '0;
        if (accept)
        begin
            if (byte_item.chunk_end)
            begin
                recent_next     = '0;
                pos_next        = '0;
                ended_next      = 1'b0;
                seen_next       = '0;
                open_next       = '0;
                trunc_next      = '0;
                pend_valid_next = 1'b0;
                pend_nl_next    = 1'b0;
                pend_match_next = '0;
                for (int k = 0; k < NKEY; k++)
                begin
                    start_next[k] = '0;
                    len_next[k]   = '0;
                end
            end
            else if (!ended_reg && pos_reg < POS_W'(CHUNK_BYTES))
            begin
                if (byte_item.data_byte == NUL)
                begin
                    ended_next      = 1'b1;
                    pend_valid_next = 1'b0;
                end
                else
                begin
                    // previous byte is now known not to be the dropped last byte
                    if (pend_valid_reg)
                    begin
                        for (int k = 0; k < NKEY; k++)
                        begin
                            if (pend_nl_reg && open_reg[k])
                            begin
                                span = pos_reg - POS_W'(1) - start_reg[k];
                                if (span > POS_W'(FIELD_MAX - 1))
                                begin
                                    len_next[k]   = LEN_W'(FIELD_MAX - 1);
                                    trunc_next[k] = 1'b1;
                                end
                                else
                                begin
                                    len_next[k]   = LEN_W'(span);
                                    trunc_next[k] = 1'b0;
                                end
                                open_next[k] = 1'b0;
                            end
                        end
                        for (int k = 0; k < NKEY; k++)
                        begin
                            if (pend_match_reg[k])
                            begin
                                seen_next[k]  = 1'b1;
                                start_next[k] = pos_reg - KEY_LEN[k];
                                open_next[k]  = 1'b1;
                                len_next[k]   = '0;
                                trunc_next[k] = 1'b0;
                            end
                        end
                    end
                    for (int k = 0; k < NKEY; k++)
                    begin
                        pend_match_next[k] = (pos_reg >= KEY_LEN[k] - POS_W'(1)) &&
                                             ((win & KEY_MASK[k]) == KEY_PATTERN[k]);
                    end
                    pend_nl_next    = (byte_item.data_byte == NEWLINE);
                    pend_valid_next = 1'b1;
                    recent_next     = win[HIST_W-1:0];
                    pos_next        = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg     <= '0;
            pos_reg        <= '0;
            ended_reg      <= 1'b0;
            seen_reg       <= '0;
            open_reg       <= '0;
            trunc_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_nl_reg    <= 1'b0;
            pend_match_reg <= '0;
            for (int k = 0; k < NKEY; k++)
            begin
                start_reg[k] <= '0;
                len_reg[k]   <= '0;
            end
        end
        else
        begin
            recent_reg     <= recent_next;
            pos_reg        <= pos_next;
            ended_reg      <= ended_next;
            seen_reg       <= seen_next;
            open_reg       <= open_next;
            trunc_reg      <= trunc_next;
            pend_valid_reg <= pend_valid_next;
            pend_nl_reg    <= pend_nl_next;
            pend_match_reg <= pend_match_next;
            start_reg      <= start_next;
            len_reg        <= len_next;
        end
    end

endmodule

/* rtl/hkle_queue.sv */
`timescale 1ns / 1ps
// Two-entry show-ahead queue of chunk summaries between tracker and emitter.
module hkle_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hkle_pkg::summary_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output hkle_pkg::summary_t head_data
);
    import hkle_pkg::*;

    summary_t   mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/hkle_back.sv */
`timescale 1ns / 1ps
// Emitter: turns each queued summary into three result items through an output register.
module hkle_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  hkle_pkg::summary_t    head_data,
    output logic                  pop,
    output logic                  field_valid,
    input  logic                  field_ready,
    output hkle_pkg::field_item_t field_item
);
    import hkle_pkg::*;

    field_kind_t idx_reg, idx_next;
    logic        valid_reg, valid_next;
    field_item_t item_reg, item_next;
    logic        load;

    assign load        = head_valid && (!valid_reg || field_ready);
    assign pop         = load && (idx_reg == KIND_REFERER);
    assign field_valid = valid_reg;
    assign field_item  = item_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        item_next  = item_reg;
        valid_next = valid_reg;
        if (load)
        begin
            item_next.field_kind      = idx_reg;
            item_next.field_start     = head_data[idx_reg].start;
            item_next.field_length    = head_data[idx_reg].length;
            item_next.field_truncated = head_data[idx_reg].truncated;
            item_next.last_field      = (idx_reg == KIND_REFERER);
            valid_next                = 1'b1;
            idx_next = (idx_reg == KIND_REFERER) ? KIND_GET : field_kind_t'(idx_reg + 2'd1);
        end
        else if (field_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= KIND_GET;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

/* rtl/http_keyword_line_extractor.sv */
`timescale 1ns / 1ps
// Top level of the HTTP keyword line extractor: tracker, summary queue, emitter.
//
//   channel  direction  handshake                  payload
//   byte     in         byte_valid / byte_ready    byte_item  (data_byte, chunk_end)
//   field    out        field_valid / field_ready  field_item (kind, start, length, flags)
//
// One byte item is taken every cycle while byte_ready is high; the tracker updates its
// keyword state in that cycle. A chunk_end item with all three keywords seen queues a
// summary (two deep), which the emitter drains as three result items back to back
// while field_ready is high. byte_ready drops only while both queue entries are occupied.
// rst_n clears all tracking state and the queue at once; no clearing pass.
module http_keyword_line_extractor (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  hkle_pkg::byte_item_t  byte_item,
    output logic                  field_valid,
    input  logic                  field_ready,
    output hkle_pkg::field_item_t field_item
);
    import hkle_pkg::*;

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_head_valid;
    summary_t q_push_data;
    summary_t q_head_data;

    hkle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_push_data)
    );

    hkle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    hkle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_data   (q_head_data),
        .pop         (q_pop),
        .field_valid (field_valid),
        .field_ready (field_ready),
        .field_item  (field_item)
    );

endmodule

/* bench/hkle_checker.sv */
`timescale 1ns / 1ps
// Checker for the HTTP keyword line extractor: tracks keywords per chunk, predicts and compares.
module hkle_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic                  byte_ready,
    input  hkle_pkg::byte_item_t  byte_item,
    input  logic                  field_valid,
    input  logic                  field_ready,
    input  hkle_pkg::field_item_t field_item,
    output int                    fail_count,
    output int                    fields_waiting
);
    import hkle_pkg::*;

    localparam logic [55:0] GET_TEXT     = 56'h00000000474554;
    localparam logic [55:0] HOST_TEXT    = 56'h000000486F7374;
    localparam logic [55:0] REFERER_TEXT = 56'h52656665726572;
    localparam int SPAN_CAP = FIELD_MAX - 1;

    localparam logic [55:0] WORD_TEXT [NKEY] = '{GET_TEXT, HOST_TEXT, REFERER_TEXT};
    localparam logic [55:0] WORD_MASK [NKEY] = '{
        56'h00000000FFFFFF, 56'h000000FFFFFFFF, 56'hFFFFFFFFFFFFFF
    };
    localparam int WORD_LEN [NKEY] = '{3, 4, 7};
    localparam field_kind_t KIND_OF [NKEY] = '{KIND_GET, KIND_HOST, KIND_REFERER};

    // per-chunk tracking
    logic [47:0] hist = '0;
    int          text_pos = 0;
    bit          text_done = 0;
    bit          kw_seen  [NKEY];
    int          kw_start [NKEY];
    bit          kw_open  [NKEY];
    int          kw_len   [NKEY];
    bit          kw_trunc [NKEY];
    // matches at the newest byte wait until a later byte shows it was not the dropped one
    bit          held_valid = 0;
    bit          held_newline = 0;
    bit          held_match [NKEY];

    field_item_t expected_fields [$];
    int          mismatches = 0;

    function automatic void clear_tracking();
        hist = '0;
        text_pos = 0;
        text_done = 0;
        held_valid = 0;
        held_newline = 0;
        for (int k = 0; k < NKEY; k++)
        begin
            kw_seen[k] = 0;
            kw_start[k] = 0;
            kw_open[k] = 0;
            kw_len[k] = 0;
            kw_trunc[k] = 0;
            held_match[k] = 0;
        end
    endfunction

    // apply the byte at position at, now known to be kept
    function automatic void settle_byte(int at);
        int span;
        if (!held_valid)
            return;
        if (held_newline)
        begin
            for (int k = 0; k < NKEY; k++)
            begin
                if (kw_open[k])
                begin
                    span = at - kw_start[k];
                    kw_trunc[k] = (span > SPAN_CAP);
                    kw_len[k] = (span > SPAN_CAP) ? SPAN_CAP : span;
                    kw_open[k] = 0;
                end
            end
        end
        for (int k = 0; k < NKEY; k++)
        begin
            if (held_match[k])
            begin
                kw_seen[k] = 1;
                kw_start[k] = at + 1 - WORD_LEN[k];
                kw_open[k] = 1;
                kw_len[k] = 0;
                kw_trunc[k] = 0;
            end
        end
        held_valid = 0;
    endfunction

    function automatic void take_byte(byte_item_t it);
        logic [55:0] win;
        field_item_t want;
        if (it.chunk_end)
        begin
            if (kw_seen[0] && kw_seen[1] && kw_seen[2])
            begin
                for (int k = 0; k < NKEY; k++)
                begin
                    want.field_kind = KIND_OF[k];
                    want.field_start = kw_open[k] ? 11'd0 : 11'(kw_start[k]);
                    want.field_length = kw_open[k] ? 10'd0 : 10'(kw_len[k]);
                    want.field_truncated = !kw_open[k] && kw_trunc[k];
                    want.last_field = (k == NKEY - 1);
                    expected_fields.push_back(want);
                end
            end
            clear_tracking();
            return;
        end
        if (text_done || text_pos >= CHUNK_BYTES)
            return;
        if (it.data_byte == NUL)
        begin
            text_done = 1;
            held_valid = 0;
            return;
        end
        if (text_pos > 0)
            settle_byte(text_pos - 1);
        win = {hist, it.data_byte};
        for (int k = 0; k < NKEY; k++)
            held_match[k] = (text_pos + 1 >= WORD_LEN[k]) &&
                            ((win & WORD_MASK[k]) == WORD_TEXT[k]);
        held_newline = (it.data_byte == NEWLINE);
        held_valid = 1;
        hist = win[47:0];
        text_pos++;
    endfunction

    function automatic void compare_value(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_field(field_item_t got);
        field_item_t want;
        if (expected_fields.size() == 0)
        begin
            $display("%0t: unexpected field item, expected none, got kind %0d start %0d length %0d",
                     $time, got.field_kind, got.field_start, got.field_length);
            mismatches++;
            return;
        end
        want = expected_fields.pop_front();
        compare_value("field_kind", 16'(want.field_kind), 16'(got.field_kind));
        compare_value("field_start", 16'(want.field_start), 16'(got.field_start));
        compare_value("field_length", 16'(want.field_length), 16'(got.field_length));
        compare_value("field_truncated", 16'(want.field_truncated), 16'(got.field_truncated));
        compare_value("last_field", 16'(want.last_field), 16'(got.last_field));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_tracking();
            expected_fields.delete();
        end
        else
        begin
            if (field_valid && field_ready)
                check_field(field_item);
            if (byte_valid && byte_ready)
                take_byte(byte_item);
        end
        fail_count <= mismatches;
        fields_waiting <= expected_fields.size();
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the HTTP keyword line extractor: request stimulus, flow control, verdict.
module tb;
    import hkle_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 370;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    byte_item_t  byte_item;
    logic        field_valid;
    logic        field_ready;
    field_item_t field_item;

    int fail_count;
    int fields_waiting;

    bit hold_off = 0;
    bit calm = 0;
    int random_items = 0;
    int cycle_count = 0;
    logic [7:0] chunk_q [$];

    http_keyword_line_extractor i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_item   (byte_item),
        .field_valid (field_valid),
        .field_ready (field_ready),
        .field_item  (field_item)
    );

    hkle_checker i_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .byte_item      (byte_item),
        .field_valid    (field_valid),
        .field_ready    (field_ready),
        .field_item     (field_item),
        .fail_count     (fail_count),
        .fields_waiting (fields_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: done, errors");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        field_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                field_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 0;
            end
            else
                field_ready <= calm || ($urandom_range(0, 99) >= 23);
        end
    end

    task automatic send_item(logic [7:0] b, logic last);
        byte_item_t it;
        it.data_byte = b;
        it.chunk_end = last;
        while (!calm && $urandom_range(0, 99) < 23)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_item <= it;
        byte_valid <= 1'b1;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            chunk_q.push_back(s[i]);
    endtask

    task automatic put_fill(logic [7:0] b, int n);
        repeat (n) chunk_q.push_back(b);
    endtask

    task automatic send_chunk();
        foreach (chunk_q[i])
            send_item(chunk_q[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        random_items += chunk_q.size() + 1;
        chunk_q.delete();
    endtask

    // sender pauses until every predicted field has come back
    task automatic drain_fields();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (fields_waiting != 0)
            @(posedge clk);
    endtask

    // header lines in random order; complete ones always carry all three keywords
    task automatic build_request(bit complete);
        int kinds [$];
        int j;
        int tmp;
        for (int k = 0; k < NKEY; k++)
            if (complete || $urandom_range(0, 99) < 88)
                kinds.push_back(k);
        if ($urandom_range(0, 99) < 25)
            kinds.push_back($urandom_range(0, 2));
        repeat ($urandom_range(0, 2)) kinds.push_back(3);
        for (int k = 0; k < kinds.size(); k++)
        begin
            j = $urandom_range(0, kinds.size() - 1);
            tmp = kinds[k];
            kinds[k] = kinds[j];
            kinds[j] = tmp;
        end
        for (int k = 0; k < kinds.size(); k++)
        begin
            case (kinds[k])
                KIND_GET:     put_text("GET");
                KIND_HOST:    put_text("Host");
                KIND_REFERER: put_text("Referer");
                default:
                    case ($urandom_range(0, 3))
                        0: put_text("Accept");
                        1: put_text("Hos");
                        2: put_text("GE");
                        default: put_text("Refere");
                    endcase
            endcase
            repeat ($urandom_range(0, 3)) chunk_q.push_back(8'($urandom_range(32, 126)));
            j = $urandom_range(0, 99);
            if (j < 55)
            begin
                chunk_q.push_back(8'h0D);
                chunk_q.push_back(NEWLINE);
            end
            else if (j < 90 || complete)
                chunk_q.push_back(NEWLINE);
        end
        if (!complete && chunk_q.size() > 0 && $urandom_range(0, 99) < 12)
            chunk_q[$urandom_range(0, chunk_q.size() - 1)] = NUL;
        if (!complete && $urandom_range(0, 99) < 12)
            repeat ($urandom_range(1, 3)) chunk_q.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int chunk_idx;
        int waited;
        rst_n <= 1'b0;
        byte_valid <= 1'b0;
        byte_item <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero byte first: empty text, later byte ignored
        chunk_q.push_back(NUL);
        chunk_q.push_back(8'hFF);
        send_chunk();
        // GET with no newline after it gives an empty field
        put_text("Referer");
        chunk_q.push_back(NEWLINE);
        put_text("Host");
        chunk_q.push_back(NEWLINE);
        put_text("GET!");
        send_chunk();

        // span of exactly the cap, not truncated
        put_text("GET");
        put_fill("a", 996);
        chunk_q.push_back(NEWLINE);
        put_text("Host");
        chunk_q.push_back(NEWLINE);
        put_text("Referer");
        chunk_q.push_back(NEWLINE);
        put_text("x");
        send_chunk();
        // one past the cap, saturated
        put_text("Referer");
        chunk_q.push_back(NEWLINE);
        put_text("Host");
        chunk_q.push_back(NEWLINE);
        put_text("GET");
        put_fill("c", 997);
        chunk_q.push_back(NEWLINE);
        put_text("y");
        send_chunk();
        // overlong chunk: Referer near the size limit, tail beyond it ignored
        put_text("GET");
        chunk_q.push_back(NEWLINE);
        put_text("Host");
        chunk_q.push_back(NEWLINE);
        put_fill("z", 1479);
        put_text("Referer");
        chunk_q.push_back(NEWLINE);
        put_text("abcdefghij");
        send_chunk();

        random_items = 0;
        chunk_idx = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (chunk_idx == 1)
            begin
                // fill the summary queue while results are held off
                hold_off = 1;
                repeat (4)
                begin
                    build_request(1'b1);
                    send_chunk();
                end
            end
            if (chunk_idx == 3)
                drain_fields();
            calm = (chunk_idx >= 4 && chunk_idx < 8);
            if ($urandom_range(0, 99) < 70)
                build_request(1'b0);
            else
            begin
                repeat ($urandom_range(0, 12)) chunk_q.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 99) < 50)
                    case ($urandom_range(0, 2))
                        KIND_GET:  put_text("GET");
                        KIND_HOST: put_text("Host");
                        default:   put_text("Referer");
                    endcase
                repeat ($urandom_range(0, 4)) chunk_q.push_back(8'($urandom_range(0, 255)));
            end
            send_chunk();
            chunk_idx++;
        end
        calm = 0;

        byte_valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (fields_waiting != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (fields_waiting != 0)
            $display("%0t: %0d expected field items never arrived", $time, fields_waiting);
        if (fail_count == 0 && fields_waiting == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
rtl/hkle_pkg.sv
rtl/hkle_front.sv
rtl/hkle_queue.sv
rtl/hkle_back.sv
rtl/http_keyword_line_extractor.sv
bench/hkle_checker.sv
bench/tb.sv
